>>> sv/udff_pkg.sv
// Shared types and constants of the unsigned decimal field formatter.
// Used by the register block, controller, datapath and top level.
package udff_pkg;

   localparam int VALUE_W    = 64;
   localparam int CHAR_W     = 8;
   localparam int FIELD_W    = 6;
   localparam int PREC_W     = 7;
   localparam int BCD_DIGITS = 20;
   localparam int DIGIT_W    = 4;
   localparam int BCD_W      = BCD_DIGITS * DIGIT_W;
   localparam int DIG_IDX_W  = $clog2(BCD_DIGITS);
   localparam int NDIG_W     = $clog2(BCD_DIGITS + 1);
   localparam int CNT_W      = $clog2(VALUE_W);
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   localparam int DEF_MAX_DIGITS = 20;
   localparam int DEF_MAX_FIELD  = 63;

   localparam logic [1:0] REG_FIELD_WIDTH  = 2'd0;
   localparam logic [1:0] REG_MIN_DIGITS   = 2'd1;
   localparam logic [1:0] REG_LEFT_JUSTIFY = 2'd2;
   localparam logic [1:0] REG_ZERO_PAD     = 2'd3;

   localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;

   typedef struct packed {
      logic [FIELD_W-1:0]       field_width;
      logic signed [PREC_W-1:0] min_digits;
      logic                     left_justify;
      logic                     zero_pad;
   } udff_cfg_type;

   typedef struct packed {
      logic load;
      logic convert;
      logic size;
      logic plan;
      logic emit;
   } udff_cmd_type;

   typedef struct packed {
      logic conv_done;
      logic emit_done;
      logic slot_free;
   } udff_sts_type;

endpackage

>>> sv/udff_csr.sv
// Configuration registers of the formatter behind an APB-style port.
// Depends on udff_pkg for register indexes and the configuration struct.
module udff_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [udff_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [udff_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [udff_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready,
   output udff_pkg::udff_cfg_type             cfg
);
   import udff_pkg::*;

   udff_cfg_type cfg_ff;
   udff_cfg_type cfg_in;
   logic         wr_en;
   logic [1:0]   reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_FIELD_WIDTH:  cfg_in.field_width  = pwdata[FIELD_W-1:0];
            REG_MIN_DIGITS:   cfg_in.min_digits   = pwdata[PREC_W-1:0];
            REG_LEFT_JUSTIFY: cfg_in.left_justify = pwdata[0];
            REG_ZERO_PAD:     cfg_in.zero_pad     = pwdata[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.field_width  <= '0;
         cfg_ff.min_digits   <= '1;
         cfg_ff.left_justify <= 1'b0;
         cfg_ff.zero_pad     <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_FIELD_WIDTH:  prdata = CSR_DATA_W'(cfg_ff.field_width);
         REG_MIN_DIGITS:   prdata = {{(CSR_DATA_W-PREC_W){cfg_ff.min_digits[PREC_W-1]}},
                                     cfg_ff.min_digits};
         REG_LEFT_JUSTIFY: prdata = CSR_DATA_W'(cfg_ff.left_justify);
         REG_ZERO_PAD:     prdata = CSR_DATA_W'(cfg_ff.zero_pad);
         default:          prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

>>> sv/udff_ctrl.sv
// Sequencing state machine of the formatter: load, convert, size, plan, emit.
// Depends on udff_pkg for the command and status structs.
module udff_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  udff_pkg::udff_sts_type  sts,
   output udff_pkg::udff_cmd_type  cmd
);
   import udff_pkg::*;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_CONVERT = 3'd1;
   localparam logic [2:0] ST_SIZE    = 3'd2;
   localparam logic [2:0] ST_PLAN    = 3'd3;
   localparam logic [2:0] ST_EMIT    = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            cmd.convert = 1'b1;
            if (sts.conv_done) begin
               state_in = ST_SIZE;
            end
         end
         ST_SIZE: begin
            cmd.size = 1'b1;
            state_in = ST_PLAN;
         end
         ST_PLAN: begin
            cmd.plan = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // advance one character whenever the output register can take it
            if (sts.slot_free) begin
               cmd.emit = 1'b1;
               if (sts.emit_done) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> sv/udff_dpath.sv
// Datapath of the formatter: shift-and-add-3 binary to BCD conversion,
// field layout, character generation and the result register. Uses udff_pkg.
module udff_dpath #(
   parameter int MAX_DIGITS = udff_pkg::DEF_MAX_DIGITS,
   parameter int MAX_FIELD  = udff_pkg::DEF_MAX_FIELD
) (
   input  logic                            clock,
   input  logic                            reset,
   input  udff_pkg::udff_cfg_type          cfg,
   input  udff_pkg::udff_cmd_type          cmd,
   output udff_pkg::udff_sts_type          sts,
   input  logic [udff_pkg::VALUE_W-1:0]    req_value,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [udff_pkg::CHAR_W-1:0]     rsp_character,
   output logic                            rsp_last,
   output logic                            rsp_empty_res
);
   import udff_pkg::*;

   localparam logic [NDIG_W-1:0]  MAXD  = NDIG_W'(MAX_DIGITS);
   localparam logic [FIELD_W-1:0] MAXF  = FIELD_W'(MAX_FIELD);

   // conversion
   logic [VALUE_W-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0]   bcd_ff, bcd_in;
   logic [BCD_W-1:0]   bcd_adj;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   // layout
   logic [NDIG_W-1:0]  ndig_ff, ndig_in;
   logic [NDIG_W-1:0]  nat;
   logic [FIELD_W-1:0] len_ff, len_in;
   logic [FIELD_W-1:0] b1_ff, b1_in;
   logic [FIELD_W-1:0] b2_ff, b2_in;
   logic [FIELD_W-1:0] b3_ff, b3_in;
   logic [CHAR_W-1:0]  padc_ff, padc_in;
   logic [FIELD_W-1:0] pos_ff, pos_in;

   logic               prec_none;
   logic [FIELD_W-1:0] prec_cap;
   logic [FIELD_W-1:0] width_cap;
   logic [FIELD_W-1:0] ndig_ext;
   logic [FIELD_W-1:0] slen;
   logic [FIELD_W-1:0] len_full;
   logic [FIELD_W-1:0] pad;
   logic [FIELD_W-1:0] zeros;
   logic [FIELD_W-1:0] lead;

   // emission
   logic [FIELD_W-1:0]   dig_pos;
   logic [DIG_IDX_W-1:0] dig_idx;
   logic [DIGIT_W-1:0]   dig_rd;
   logic [CHAR_W-1:0]    ch;
   logic                 ch_empty;
   logic                 ch_last;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]    rsp_char_ff, rsp_char_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 rsp_empty_ff, rsp_empty_in;

   // add 3 to every digit of 5 or more before the shift
   always_comb begin
      logic [DIGIT_W-1:0] dv;
      dv = '0;
      for (int i = 0; i < BCD_DIGITS; i++) begin
         dv = bcd_ff[i*DIGIT_W +: DIGIT_W];
         bcd_adj[i*DIGIT_W +: DIGIT_W] = (dv >= DIGIT_W'(5)) ? dv + DIGIT_W'(3) : dv;
      end
   end

   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      cnt_in = cnt_ff;
      if (cmd.load) begin
         bin_in = req_value;
         bcd_in = '0;
         cnt_in = '0;
      end else if (cmd.convert) begin
         bcd_in = {bcd_adj[BCD_W-2:0], bin_ff[VALUE_W-1]};
         bin_in = {bin_ff[VALUE_W-2:0], 1'b0};
         cnt_in = cnt_ff + CNT_W'(1);
      end
   end

   assign sts.conv_done = (cnt_ff == CNT_W'(VALUE_W - 1));

   // most significant nonzero digit gives the natural digit count
   always_comb begin
      nat = '0;
      for (int i = 0; i < BCD_DIGITS; i++) begin
         if (bcd_ff[i*DIGIT_W +: DIGIT_W] != '0) begin
            nat = NDIG_W'(i + 1);
         end
      end
   end

   assign prec_none = cfg.min_digits[PREC_W-1];
   assign prec_cap  = (cfg.min_digits[FIELD_W-1:0] > MAXF) ? MAXF
                                                           : cfg.min_digits[FIELD_W-1:0];
   assign width_cap = (cfg.field_width > MAXF) ? MAXF : cfg.field_width;

   always_comb begin
      ndig_in = ndig_ff;
      if (cmd.size) begin
         // zero value with precision zero prints no digits
         if (nat == '0 && !prec_none && prec_cap == '0) begin
            ndig_in = '0;
         end else if (nat == '0) begin
            ndig_in = NDIG_W'(1);
         end else if (nat > MAXD) begin
            ndig_in = MAXD;
         end else begin
            ndig_in = nat;
         end
      end
   end

   assign ndig_ext = FIELD_W'(ndig_ff);
   assign slen     = (prec_none || ndig_ext > prec_cap) ? ndig_ext : prec_cap;
   assign len_full = (width_cap > slen) ? width_cap : slen;
   assign pad      = len_full - slen;
   assign zeros    = slen - ndig_ext;
   assign lead     = cfg.left_justify ? '0 : pad;

   always_comb begin
      len_in  = len_ff;
      b1_in   = b1_ff;
      b2_in   = b2_ff;
      b3_in   = b3_ff;
      padc_in = padc_ff;
      if (cmd.plan) begin
         len_in  = len_full;
         b1_in   = lead;
         b2_in   = lead + zeros;
         b3_in   = lead + zeros + ndig_ext;
         padc_in = (cfg.zero_pad && prec_none) ? CH_ZERO : CH_SPACE;
      end
   end

   // digits sit least significant first: walk them downward
   assign dig_pos = b3_ff - pos_ff - FIELD_W'(1);
   assign dig_idx = dig_pos[DIG_IDX_W-1:0];
   assign dig_rd  = bcd_ff[dig_idx*DIGIT_W +: DIGIT_W];

   always_comb begin
      ch_empty = 1'b0;
      ch_last  = (pos_ff == len_ff - FIELD_W'(1));
      if (len_ff == '0) begin
         ch       = CH_NUL;
         ch_empty = 1'b1;
         ch_last  = 1'b1;
      end else if (pos_ff < b1_ff) begin
         ch = padc_ff;
      end else if (pos_ff < b2_ff) begin
         ch = CH_ZERO;
      end else if (pos_ff < b3_ff) begin
         ch = CH_ZERO + CHAR_W'(dig_rd);
      end else begin
         ch = CH_SPACE;
      end
   end

   assign sts.emit_done = ch_last;
   assign sts.slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_empty_in = rsp_empty_ff;
      if (cmd.plan) begin
         pos_in = '0;
      end
      if (cmd.emit) begin
         pos_in       = ch_last ? '0 : pos_ff + FIELD_W'(1);
         rsp_valid_in = 1'b1;
         rsp_char_in  = ch;
         rsp_last_in  = ch_last;
         rsp_empty_in = ch_empty;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff       <= bin_in;
      bcd_ff       <= bcd_in;
      ndig_ff      <= ndig_in;
      len_ff       <= len_in;
      b1_ff        <= b1_in;
      b2_ff        <= b2_in;
      b3_ff        <= b3_in;
      padc_ff      <= padc_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_empty_res = rsp_empty_ff;

   assert property (@(posedge clock) disable iff (reset)
      cmd.emit && sts.emit_done |=> pos_ff == '0)
      else $error("character position not back at zero after the last transfer");

   assert property (@(posedge clock) disable iff (reset)
      cmd.size |=> ndig_ff <= MAXD)
      else $error("digit count exceeds the kept digits");

   assert property (@(posedge clock) disable iff (reset)
      cmd.plan |=> (b1_ff <= b2_ff) && (b2_ff <= b3_ff) && (b3_ff <= len_ff))
      else $error("field layout boundaries out of order");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_empty_ff |-> rsp_last_ff)
      else $error("empty field result not marked last");

endmodule

>>> sv/unsigned_decimal_field_formatter.sv
// printf-style %u formatter: each 64-bit value on req_ becomes a run of ASCII
// characters on rsp_, one per transfer, with rsp_last on the final one and a single
// rsp_empty_res transfer when the field is empty. An item passes through an accept
// step, one-bit-per-cycle binary to BCD conversion, the size and plan layout steps
// and then emission at one character per cycle while the output register can take
// it; the conversion loop and the single character port bound the item rate. A new
// value is taken once the last character sits in the output
// register. Configuration is written through psel/penable/pwrite at 4*index.
module unsigned_decimal_field_formatter #(
   parameter int MAX_DIGITS = udff_pkg::DEF_MAX_DIGITS,
   parameter int MAX_FIELD  = udff_pkg::DEF_MAX_FIELD
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [udff_pkg::VALUE_W-1:0]     req_value,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [udff_pkg::CHAR_W-1:0]      rsp_character,
   output logic                             rsp_last,
   output logic                             rsp_empty_res,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [udff_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [udff_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [udff_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready
);
   import udff_pkg::*;

   udff_cfg_type cfg;
   udff_cmd_type cmd;
   udff_sts_type sts;

   udff_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   udff_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   udff_dpath #(
      .MAX_DIGITS (MAX_DIGITS),
      .MAX_FIELD  (MAX_FIELD)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .cmd           (cmd),
      .sts           (sts),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last),
      .rsp_empty_res (rsp_empty_res)
   );

endmodule

>>> tb/tb_unsigned_decimal_field_formatter.sv
`timescale 1ns / 1ps
// Self-checking testbench for unsigned_decimal_field_formatter (printf %u text output).
// Depends on udff_pkg and the formatter RTL; predicts every character in-line.
module tb_unsigned_decimal_field_formatter;
   import udff_pkg::*;

   localparam int HOLD_CYCLES    = 500;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int TAIL_CYCLES    = 140;
   localparam int REPORT_LIMIT   = 10;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              is_last;
      logic              is_empty;
   } field_char_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [VALUE_W-1:0]    req_value = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [CHAR_W-1:0]     rsp_character;
   logic                  rsp_last;
   logic                  rsp_empty_res;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // local copy of the format registers
   int cfg_width;
   int cfg_min_digits;
   bit cfg_left;
   bit cfg_zero;

   field_char_type expected_chars[$];
   int  failures = 0;
   int  mismatches = 0;
   bit  src_idle_en = 1'b0;
   bit  sink_idle_en = 1'b0;
   int  hold_ticket = 0;
   int  hold_seen = 0;
   int  hold_left = 0;
   int  sink_stall = 0;
   int  quiet_cycles = 0;

   unsigned_decimal_field_formatter dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_character(rsp_character),
      .rsp_last(rsp_last), .rsp_empty_res(rsp_empty_res),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Work out the characters of one formatted field and queue them.
   function automatic void format_expected(input logic [VALUE_W-1:0] value);
      logic [DIGIT_W-1:0] digits [DEF_MAX_DIGITS];
      logic [VALUE_W-1:0] rest;
      logic [CHAR_W-1:0]  pad_ch;
      field_char_type     fc;
      int ndig, prec, width, slen, flen, lead, zeros, k;
      ndig  = 0;
      prec  = (cfg_min_digits < 0) ? -1 : cfg_min_digits;
      width = cfg_width;
      if (prec > DEF_MAX_FIELD) prec = DEF_MAX_FIELD;
      if (width > DEF_MAX_FIELD) width = DEF_MAX_FIELD;
      if (!(value == 0 && prec == 0)) begin
         rest = value;
         do begin
            digits[ndig] = DIGIT_W'(rest % 10);
            ndig++;
            rest = rest / 10;
         end while (rest != 0 && ndig < DEF_MAX_DIGITS);
      end
      slen = (prec > ndig) ? prec : ndig;
      flen = (width > slen) ? width : slen;
      if (flen == 0) begin
         fc.ch = CH_NUL;
         fc.is_last = 1'b1;
         fc.is_empty = 1'b1;
         expected_chars.push_back(fc);
         return;
      end
      zeros  = slen - ndig;
      lead   = cfg_left ? 0 : flen - slen;
      pad_ch = (cfg_zero && prec < 0) ? CH_ZERO : CH_SPACE;
      for (int p = 0; p < flen; p++) begin
         if (p < lead) begin
            fc.ch = pad_ch;
         end else if (p < lead + zeros) begin
            fc.ch = CH_ZERO;
         end else if (p < lead + zeros + ndig) begin
            k = ndig - 1 - (p - lead - zeros);
            fc.ch = CH_ZERO + digits[k];
         end else begin
            fc.ch = CH_SPACE;
         end
         fc.is_last = (p == flen - 1);
         fc.is_empty = 1'b0;
         expected_chars.push_back(fc);
      end
   endfunction

   function automatic void report_bad_char(input string what, input field_char_type want);
      failures++;
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("%s: expected char %h last %b empty %b, got char %h last %b empty %b",
                  what, want.ch, want.is_last, want.is_empty,
                  rsp_character, rsp_last, rsp_empty_res);
   endfunction

   // Result side: check each transfer, then pick the next ready value.
   always @(posedge clock) begin
      field_char_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               want = '0;
               report_bad_char("unexpected transfer", want);
            end else begin
               want = expected_chars.pop_front();
               if (rsp_last !== want.is_last || rsp_empty_res !== want.is_empty ||
                   (!want.is_empty && rsp_character !== want.ch))
                  report_bad_char("mismatch", want);
            end
         end
         if (hold_seen != hold_ticket) begin
            hold_seen = hold_ticket;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (sink_stall > 0) begin
            sink_stall--;
            rsp_ready <= 1'b0;
         end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
            sink_stall = $urandom_range(1, 7) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Abort when nothing moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_value(input logic [VALUE_W-1:0] value);
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
      format_expected(value);
      if (src_idle_en && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      case (index)
         REG_FIELD_WIDTH:  cfg_width = int'(data[FIELD_W-1:0]);
         REG_MIN_DIGITS:   cfg_min_digits = int'($signed(data[PREC_W-1:0]));
         REG_LEFT_JUSTIFY: cfg_left = data[0];
         REG_ZERO_PAD:     cfg_zero = data[0];
         default: ;
      endcase
   endtask

   task automatic set_format(input int width, input int prec, input bit left, input bit zero);
      logic [PREC_W-1:0] prec_bits;
      prec_bits = prec[PREC_W-1:0];
      wait_drained();
      write_csr(REG_FIELD_WIDTH, CSR_DATA_W'(width[FIELD_W-1:0]));
      write_csr(REG_MIN_DIGITS, CSR_DATA_W'(prec_bits));
      write_csr(REG_LEFT_JUSTIFY, CSR_DATA_W'(left));
      write_csr(REG_ZERO_PAD, CSR_DATA_W'(zero));
   endtask

   // Mix of zero, short numbers, decade edges and full-width values.
   function automatic logic [VALUE_W-1:0] random_value();
      logic [VALUE_W-1:0] p;
      case ($urandom_range(0, 5))
         0: return '0;
         1: return VALUE_W'($urandom_range(0, 999));
         2: begin
            p = 1;
            repeat ($urandom_range(0, 19)) p = p * 10;
            return p - VALUE_W'($urandom_range(0, 1));
         end
         default: return {$urandom, $urandom} >> $urandom_range(0, 63);
      endcase
   endfunction

   task automatic test_reset_defaults();
      send_value(64'd0);
      send_value(64'd1);
      send_value(64'd9);
      send_value(64'd10);
      send_value(64'hFFFF_FFFF_FFFF_FFFF);
      send_value(64'd10000000000000000000);
      send_value(64'd9999999999999999999);
   endtask

   task automatic test_empty_field();
      set_format(0, 0, 1'b0, 1'b0);
      send_value(64'd0);
      send_value(64'd7);
      set_format(3, 0, 1'b0, 1'b1);
      send_value(64'd0);
   endtask

   task automatic test_precision();
      // zero flag is ignored once a precision is given
      set_format(10, 5, 1'b0, 1'b1);
      send_value(64'd42);
      send_value(64'd0);
      set_format(0, 63, 1'b0, 1'b0);
      send_value(64'd123);
      // any negative precision means none given
      set_format(8, -64, 1'b0, 1'b1);
      send_value(64'd42);
   endtask

   task automatic test_width_padding();
      set_format(63, -1, 1'b0, 1'b0);
      send_value(64'hFFFF_FFFF_FFFF_FFFF);
      set_format(63, -1, 1'b1, 1'b0);
      send_value(64'd5);
      // left justify wins over the zero flag
      set_format(12, -1, 1'b1, 1'b1);
      send_value(64'd5);
      set_format(1, -1, 1'b0, 1'b1);
      send_value(64'd12345);
   endtask

   task automatic test_random_settings(input int phases, input int per_phase);
      int width, prec;
      for (int ph = 0; ph < phases; ph++) begin
         case ($urandom_range(0, 3))
            0: width = 0;
            1: width = 63;
            default: width = int'($urandom_range(0, 24));
         endcase
         case ($urandom_range(0, 5))
            0: prec = -64;
            1: prec = -1;
            2: prec = 0;
            3: prec = 63;
            default: prec = int'($urandom_range(0, 127)) - 64;
         endcase
         set_format(width, prec, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         src_idle_en  = (ph % 3 != 2);
         sink_idle_en = (ph % 4 != 3);
         for (int i = 0; i < per_phase; i++) send_value(random_value());
      end
   endtask

   task automatic test_backpressure();
      set_format(20, -1, 1'b0, 1'b1);
      src_idle_en = 1'b0;
      hold_ticket <= hold_ticket + 1;
      // keep offering while the sink is held off so the input stalls
      for (int i = 0; i < 8; i++) send_value(random_value());
      wait_drained();
      for (int i = 0; i < 4; i++) send_value(random_value());
   endtask

   task automatic test_steady_stream();
      src_idle_en  = 1'b0;
      sink_idle_en = 1'b0;
      set_format(int'($urandom_range(0, 30)), int'($urandom_range(0, 40)) - 20,
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      for (int i = 0; i < 36; i++) send_value(random_value());
   endtask

   initial begin
      cfg_width      = 0;
      cfg_min_digits = -1;
      cfg_left       = 1'b0;
      cfg_zero       = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      src_idle_en  = 1'b1;
      sink_idle_en = 1'b1;
      test_reset_defaults();
      test_empty_field();
      test_precision();
      test_width_padding();
      test_random_settings(8, 34);
      test_backpressure();
      test_steady_stream();
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      failures += expected_chars.size();
      if (failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

>>> filelist.f
sv/udff_pkg.sv
sv/udff_csr.sv
sv/udff_ctrl.sv
sv/udff_dpath.sv
sv/unsigned_decimal_field_formatter.sv
tb/tb_unsigned_decimal_field_formatter.sv
